// File: hw/rtl/run_length_text_decoder_assert.svh
// ----------------------------------------------------------------------------
// run-length text decoder assertion macros
// shared assertion forms, clocked on i_clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_TEXT_DECODER_ASSERT_SVH
`define RUN_LENGTH_TEXT_DECODER_ASSERT_SVH

// property must hold at every edge outside reset
`define RLTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define RLTD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/rltd_pkg.sv
// ----------------------------------------------------------------------------
// rltd_pkg
// shared types and constants of the run-length text decoder
// ----------------------------------------------------------------------------
package rltd_pkg;

    localparam int CHAR_W          = 8;
    localparam int CFG_W           = 7;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 2;
    localparam int MAX_LIMIT_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_W-1:0]      CFG_RESET        = 7'd50;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_OUT_LEN = 2'd0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // one command from front to back, the run count travels beside it
    typedef struct packed {
        logic [CHAR_W-1:0] sym;
        logic              has_char;
        logic              too_long;
        logic              done;
    } t_cmd_ctl;

endpackage

// File: hw/rtl/rltd_front.sv
// ----------------------------------------------------------------------------
// rltd_front
// accepts encoded bytes, builds counts, checks the length limit, issues commands
// ----------------------------------------------------------------------------
module rltd_front #(
    parameter int MAX_LIMIT = rltd_pkg::MAX_LIMIT_DEF,
    parameter int CNT_W     = $clog2(MAX_LIMIT + 2)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [rltd_pkg::CHAR_W-1:0] i_char_in,
    input  logic                     i_message_end,
    input  logic [rltd_pkg::CFG_W-1:0]  i_limit,
    output logic                     o_push,
    output rltd_pkg::t_cmd_ctl       o_ctl,
    output logic [CNT_W-1:0]         o_cnt
);
    import rltd_pkg::*;

    localparam int SUM_W = CNT_W + 1;
    localparam int MUL_W = CNT_W + 4;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0] r_pend, n_pend;
    logic             r_seen, n_seen;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;

    logic             is_digit;
    logic [CHAR_W-1:0] digit_full;
    logic [MUL_W-1:0] prod;
    logic [CNT_W-1:0] run;
    logic [CFG_W-1:0] lim_clamp;
    logic [SUM_W-1:0] lim;
    logic             over;

    assign is_digit   = (i_char_in >= CHAR_ZERO) && (i_char_in <= CHAR_NINE);
    assign digit_full = i_char_in - CHAR_ZERO;
    // count * 10 + digit
    assign prod = (MUL_W'(r_pend) << 3) + (MUL_W'(r_pend) << 1) + MUL_W'(digit_full[3:0]);
    assign run  = r_seen ? r_pend : CNT_ONE;

    assign lim_clamp = (i_limit > CFG_W'(MAX_LIMIT)) ? CFG_W'(MAX_LIMIT) : i_limit;
    assign lim       = SUM_W'(lim_clamp);
    assign over      = (SUM_W'(r_len) + SUM_W'(run)) > lim;

    always_comb begin
        n_pend = r_pend;
        n_seen = r_seen;
        n_len  = r_len;
        n_ovf  = r_ovf;
        o_push = 1'b0;
        o_ctl  = '0;
        o_cnt  = CNT_ONE;
        if (i_accept) begin
            if (r_ovf) begin
                // dropping bytes until the end of the message
                if (i_message_end) begin
                    n_ovf = 1'b0;
                    n_len = '0;
                    n_pend = '0;
                    n_seen = 1'b0;
                end
            end else if (is_digit) begin
                n_pend = (prod > MUL_W'(CNT_SAT)) ? CNT_SAT : CNT_W'(prod);
                n_seen = 1'b1;
                if (i_message_end) begin
                    o_push     = 1'b1;
                    o_ctl.done = 1'b1;
                    n_pend     = '0;
                    n_seen     = 1'b0;
                    n_len      = '0;
                end
            end else begin
                n_pend = '0;
                n_seen = 1'b0;
                if (over) begin
                    o_push         = 1'b1;
                    o_ctl.too_long = 1'b1;
                    o_ctl.done     = 1'b1;
                    n_ovf          = !i_message_end;
                    n_len          = i_message_end ? '0 : r_len;
                end else if (run != '0) begin
                    o_push         = 1'b1;
                    o_ctl.sym      = i_char_in;
                    o_ctl.has_char = 1'b1;
                    o_ctl.done     = i_message_end;
                    o_cnt          = run;
                    n_len          = i_message_end ? '0 : r_len + run;
                end else if (i_message_end) begin
                    o_push     = 1'b1;
                    o_ctl.done = 1'b1;
                    n_len      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_seen <= 1'b0;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_seen <= n_seen;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
        end
    end

endmodule

// File: hw/rtl/rltd_cmd_queue.sv
// ----------------------------------------------------------------------------
// rltd_cmd_queue
// short register queue of commands between front and back
// ----------------------------------------------------------------------------
module rltd_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rltd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_nonempty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_wr, do_rd;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && o_nonempty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
        end
        if (do_rd) begin
            n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
        end
        case ({do_wr, do_rd})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hw/rtl/rltd_back.sv
// ----------------------------------------------------------------------------
// rltd_back
// expands commands into result words in the output register, one a cycle while it is free
// ----------------------------------------------------------------------------
module rltd_back #(
    parameter int MAX_LIMIT = rltd_pkg::MAX_LIMIT_DEF,
    parameter int CNT_W     = $clog2(MAX_LIMIT + 2)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nonempty,
    input  rltd_pkg::t_cmd_ctl i_q_ctl,
    input  logic [CNT_W-1:0]   i_q_cnt,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_valid,
    output rltd_pkg::t_cmd_ctl o_ctl,
    output logic               o_last
);
    import rltd_pkg::*;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic             r_active, n_active;
    logic [CNT_W-1:0] r_left, n_left;
    t_cmd_ctl         r_ctl;
    logic             r_out_valid, n_out_valid;
    t_cmd_ctl         r_out_ctl;
    logic             r_out_last;

    logic             out_free;
    logic             emit;
    logic             is_last;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_active && out_free;
    assign is_last  = (r_left == CNT_ONE);
    // fetch the next command as the current one finishes
    assign o_q_rd   = i_q_nonempty && (!r_active || (emit && is_last));

    always_comb begin
        n_active    = r_active;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
            if (is_last) begin
                n_active = 1'b0;
            end else begin
                n_left = r_left - CNT_ONE;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (o_q_rd) begin
            n_active = 1'b1;
            n_left   = i_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_ctl <= i_q_ctl;
        end
        if (emit) begin
            r_out_ctl  <= '{sym: r_ctl.sym, has_char: r_ctl.has_char,
                            too_long: r_ctl.too_long, done: r_ctl.done && is_last};
            r_out_last <= is_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ctl   = r_out_ctl;
    assign o_last  = r_out_last;

`include "run_length_text_decoder_assert.svh"

    `RLTD_NEVER(a_left_nonzero, r_active && (r_left == '0), "active run with zero count")
    `RLTD_ASSERT(a_too_long_form, (r_out_valid && r_out_ctl.too_long) |-> (r_out_ctl.done && r_out_last && !r_out_ctl.has_char), "malformed too_long word")
    `RLTD_ASSERT(a_done_is_last, (r_out_valid && r_out_ctl.done) |-> r_out_last, "message end not on last word")
    `RLTD_ASSERT(a_run_continues, (r_out_valid && i_pop && !r_out_last) |=> (r_out_valid && (r_out_ctl.sym == $past(r_out_ctl.sym))), "run broken")

endmodule

// File: hw/rtl/run_length_text_decoder.sv
// ----------------------------------------------------------------------------
// run_length_text_decoder
// decimal-count run-length text decoder with a length limit
//
// usage:
//   input queue side: drive i_char_in and i_message_end with push; a word
//   is taken at an edge with push high and full low. digits build a count,
//   any other byte is emitted count times (once with no count).
//   result queue side: while empty is low the oldest result is on the o_
//   ports; pop high takes it. too_long ends a message early and the partial
//   output must be discarded downstream.
//   config: apb-style, max_output_length at byte address 0, pready tied high.
// path: a taken byte reaches the o_ ports through the command queue, the
//   expansion unit and the output register. throughput: one word a cycle
//   in and out while neither side stalls; a run of n bytes keeps the
//   expansion unit busy for n words, and the two-entry queue then raises full.
// reset: state clears, the limit returns to 50, the queues empty.
// when the receiver stalls the result holds, the command queue fills and
//   full rises; nothing is lost.
// ----------------------------------------------------------------------------
module run_length_text_decoder #(
    parameter int MAX_LIMIT   = rltd_pkg::MAX_LIMIT_DEF,
    parameter int QUEUE_DEPTH = rltd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [rltd_pkg::CHAR_W-1:0]      i_char_in,
    input  logic                             i_message_end,
    output logic                             empty,
    input  logic                             pop,
    output logic [rltd_pkg::CHAR_W-1:0]      o_char_out,
    output logic                             o_has_char,
    output logic                             o_too_long,
    output logic                             o_last_of_run,
    output logic                             o_message_done,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rltd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rltd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rltd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import rltd_pkg::*;

    localparam int CNT_W = $clog2(MAX_LIMIT + 2);
    localparam int Q_W   = $bits(t_cmd_ctl) + CNT_W;

    logic [CFG_W-1:0] r_max_len;
    logic             accept;
    logic             f_push;
    t_cmd_ctl         f_ctl;
    logic [CNT_W-1:0] f_cnt;
    logic [Q_W-1:0]   q_rdata;
    logic             q_rd, q_full, q_nonempty;
    logic             b_valid;
    t_cmd_ctl         b_ctl;
    logic             b_last;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_OUT_LEN) ? APB_DATA_W'(r_max_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= CFG_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_MAX_OUT_LEN)) begin
            r_max_len <= pwdata[CFG_W-1:0];
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    rltd_front #(
        .MAX_LIMIT (MAX_LIMIT),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char_in     (i_char_in),
        .i_message_end (i_message_end),
        .i_limit       (r_max_len),
        .o_push        (f_push),
        .o_ctl         (f_ctl),
        .o_cnt         (f_cnt)
    );

    rltd_cmd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (f_push),
        .i_data     ({f_cnt, f_ctl}),
        .i_rd       (q_rd),
        .o_data     (q_rdata),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    rltd_back #(
        .MAX_LIMIT (MAX_LIMIT),
        .CNT_W     (CNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_ctl      (t_cmd_ctl'(q_rdata[$bits(t_cmd_ctl)-1:0])),
        .i_q_cnt      (q_rdata[Q_W-1:$bits(t_cmd_ctl)]),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_valid      (b_valid),
        .o_ctl        (b_ctl),
        .o_last       (b_last)
    );

    assign empty          = !b_valid;
    assign o_char_out     = b_ctl.sym;
    assign o_has_char     = b_ctl.has_char;
    assign o_too_long     = b_ctl.too_long;
    assign o_last_of_run  = b_last;
    assign o_message_done = b_ctl.done;

endmodule

// File: dv/tb_run_length_text_decoder.sv
// ----------------------------------------------------------------------------
// tb_run_length_text_decoder
// self-checking bench: a directed table of encoded bytes, then random
// messages under several length limits, all checked in order against the
// table's typed results or a cycle-free model of the decoder; both queue
// sides stall at random
module tb_run_length_text_decoder;

    import rltd_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int MAX_LIMIT   = MAX_LIMIT_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_TAIL   = 12;
    localparam int PHASE_WORDS = 35;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              has_char;
        logic              too_long;
        logic              last_of_run;
        logic              message_done;
    } t_decoded;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eom;
        logic              typed;
        t_decoded          res;
    } t_stim_row;

    localparam t_decoded NO_RES   = '0;
    localparam t_decoded MARKER   = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam t_decoded TOO_LONG = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  push          = 1'b0;
    logic                  full;
    logic [CHAR_W-1:0]     i_char_in     = '0;
    logic                  i_message_end = 1'b0;
    logic                  empty;
    logic                  pop           = 1'b0;
    logic [CHAR_W-1:0]     o_char_out;
    logic                  o_has_char;
    logic                  o_too_long;
    logic                  o_last_of_run;
    logic                  o_message_done;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // decoder model state
    logic [CFG_W-1:0] length_limit = CFG_RESET;
    logic [CFG_W-1:0] run_count    = '0;
    logic             count_valid  = 1'b0;
    logic [CFG_W-1:0] msg_length   = '0;
    logic             msg_overflow = 1'b0;

    t_decoded decoded_words [$];
    int       error_count = 0;
    int       words_sent  = 0;
    int       cycle_count = 0;
    int       pop_wait    = 0;
    bit       calm        = 1'b0;

    // directed rows, limit 50 after reset
    t_stim_row dir_rows [0:22] = '{
        '{8'h61, 1'b0, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b1, 1'b0}}, // a
        '{8'h33, 1'b0, 1'b0, NO_RES},                           // 3
        '{8'h62, 1'b0, 1'b0, NO_RES},                           // b x3
        '{8'h30, 1'b0, 1'b0, NO_RES},                           // 0
        '{8'h78, 1'b0, 1'b0, NO_RES},                           // x x0
        '{8'h35, 1'b1, 1'b1, MARKER},                           // 5, dropped at end
        '{8'h39, 1'b0, 1'b0, NO_RES},                           // 9
        '{8'h39, 1'b0, 1'b0, NO_RES},                           // 9, saturates
        '{8'h7a, 1'b0, 1'b1, TOO_LONG},                         // z
        '{8'h71, 1'b0, 1'b0, NO_RES},                           // dropped
        '{8'h37, 1'b1, 1'b0, NO_RES},                           // dropped, clears
        '{8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{8'h32, 1'b0, 1'b0, NO_RES},                           // 2
        '{8'h38, 1'b0, 1'b0, NO_RES},                           // 8
        '{8'h2f, 1'b0, 1'b0, NO_RES},                           // just below '0'
        '{8'h3a, 1'b1, 1'b1, '{8'h3a, 1'b1, 1'b0, 1'b1, 1'b1}}, // just above '9'
        '{8'h30, 1'b0, 1'b0, NO_RES},                           // 0
        '{8'h6b, 1'b1, 1'b1, MARKER},                           // k x0 at end
        '{8'h35, 1'b0, 1'b0, NO_RES},                           // 5
        '{8'h30, 1'b0, 1'b0, NO_RES},                           // 0
        '{8'h6d, 1'b0, 1'b0, NO_RES},                           // m x50, at limit
        '{8'h6e, 1'b1, 1'b1, TOO_LONG}                          // one past limit
    };

    run_length_text_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_in      (i_char_in),
        .i_message_end  (i_message_end),
        .empty          (empty),
        .pop            (pop),
        .o_char_out     (o_char_out),
        .o_has_char     (o_has_char),
        .o_too_long     (o_too_long),
        .o_last_of_run  (o_last_of_run),
        .o_message_done (o_message_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void start_message();
        run_count    = '0;
        count_valid  = 1'b0;
        msg_length   = '0;
        msg_overflow = 1'b0;
    endfunction

    // appends the decoded words one encoded byte gives
    function automatic void decode_byte(input logic [CHAR_W-1:0] ch, input logic eom);
        int lim;
        int run;
        int n;
        t_decoded w;
        lim = (int'(length_limit) > MAX_LIMIT) ? MAX_LIMIT : int'(length_limit);
        n = 0;
        if (msg_overflow) begin
            if (eom) start_message();
            return;
        end
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            run = int'(run_count) * 10 + int'(ch) - int'(CHAR_ZERO);
            if (run > MAX_LIMIT + 1) run = MAX_LIMIT + 1;
            run_count   = run[CFG_W-1:0];
            count_valid = 1'b1;
        end else begin
            run = count_valid ? int'(run_count) : 1;
            run_count   = '0;
            count_valid = 1'b0;
            if (int'(msg_length) + run > lim) begin
                msg_overflow = 1'b1;
                decoded_words.push_back(TOO_LONG);
                if (eom) start_message();
                return;
            end
            for (int i = 0; i < run; i++) begin
                w.char_out     = ch;
                w.has_char     = 1'b1;
                w.too_long     = 1'b0;
                w.last_of_run  = (i == run - 1);
                w.message_done = eom && (i == run - 1);
                decoded_words.push_back(w);
                n++;
            end
            msg_length = msg_length + run[CFG_W-1:0];
        end
        if (eom) begin
            if (n == 0) decoded_words.push_back(MARKER);
            start_message();
        end
    endfunction

    // call at a rising edge; returns at the edge that takes the word
    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic eom,
                             input logic typed, input t_decoded res);
        int gap;
        int before_cnt;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_char_in     <= ch;
        i_message_end <= eom;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        before_cnt = decoded_words.size();
        decode_byte(ch, eom);
        if (typed) begin
            while (decoded_words.size() > before_cnt) void'(decoded_words.pop_back());
            decoded_words.push_back(res);
        end
        words_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (decoded_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // write or read the limit register; a read checks the returned value
    task automatic reg_access(input logic wr, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_MAX_OUT_LEN;
        pwdata  <= wr ? APB_DATA_W'(value) : '0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr) length_limit = value;
        else if (prdata !== APB_DATA_W'(value))
            report_mismatch($sformatf("limit reads %0h, want %0h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_message();
        int tokens;
        int kind;
        int ndig;
        logic [CHAR_W-1:0] sym;
        logic last;
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++) begin
            kind = $urandom_range(0, 9);
            ndig = (kind < 5) ? 1 : (kind < 7) ? 2 : (kind == 7) ? 3 : 0;
            for (int d = 0; d < ndig; d++) begin
                // keep two-digit counts mostly within reach of the limit
                if (d == 0 && ndig == 2)
                    send_word(CHAR_ZERO + CHAR_W'($urandom_range(0, 3)), 1'b0, 1'b0,
                              NO_RES);
                else
                    send_word(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0, 1'b0,
                              NO_RES);
            end
            do sym = CHAR_W'($urandom_range(0, 255));
            while (sym >= CHAR_ZERO && sym <= CHAR_NINE);
            last = (t == tokens - 1);
            if (last && $urandom_range(0, 7) == 0) begin
                // message closed by a dangling digit
                send_word(sym, 1'b0, 1'b0, NO_RES);
                send_word(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b1, 1'b0, NO_RES);
            end else begin
                send_word(sym, last, 1'b0, NO_RES);
            end
        end
    endtask

    // result side: take words with random stalls, compare in order
    always @(posedge i_clk) begin : result_side
        t_decoded got;
        t_decoded want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                got = '{o_char_out, o_has_char, o_too_long, o_last_of_run, o_message_done};
                if (decoded_words.size() == 0) begin
                    report_mismatch($sformatf("word %h with nothing outstanding", got));
                end else begin
                    want = decoded_words.pop_front();
                    if (got.char_out !== want.char_out || got.has_char !== want.has_char ||
                        got.too_long !== want.too_long ||
                        got.last_of_run !== want.last_of_run ||
                        got.message_done !== want.message_done)
                        report_mismatch($sformatf(
                            "char %h has %b long %b last %b done %b, want %h %b %b %b %b",
                            got.char_out, got.has_char, got.too_long, got.last_of_run,
                            got.message_done, want.char_out, want.has_char,
                            want.too_long, want.last_of_run, want.message_done));
                end
                pop_wait = draw_gap();
            end else if (pop_wait > 0) begin
                pop_wait--;
            end
            pop <= (pop_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run_length_text_decoder regression: fail");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] lim;
        int phase_start;
        logic [CFG_W-1:0] fixed_limits [0:4];
        fixed_limits = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reg_access(1'b0, CFG_RESET);

        foreach (dir_rows[r])
            send_word(dir_rows[r].ch, dir_rows[r].eom, dir_rows[r].typed, dir_rows[r].res);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            lim = (p < 5) ? fixed_limits[p] : CFG_W'($urandom_range(1, 64));
            reg_access(1'b1, lim);
            reg_access(1'b0, lim);
            phase_start = words_sent;
            while (words_sent < phase_start + PHASE_WORDS) begin
                calm = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 4) == 0)
                    send_word(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                              1'b0, NO_RES);
                else
                    send_message();
            end
            calm = 1'b0;
            // close any open message before the limit changes
            send_word(CHAR_ZERO, 1'b1, 1'b0, NO_RES);
            wait_idle();
        end

        if (error_count == 0)
            $display("run_length_text_decoder regression: pass");
        else
            $display("run_length_text_decoder regression: fail");
        $finish;
    end

endmodule
